// File: design/rwp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the rotor wheel permutation block.
// No dependencies; every other design file imports this package.
package rwp_pkg;

  // Wheel geometry and field widths
  localparam int unsigned WHEEL_SIZE = 256;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned TURNS_W    = 25;
  localparam int unsigned SUM_W      = TICK_W + 1;
  localparam int unsigned DIV_W      = BYTE_W + 1;
  localparam int unsigned WHEEL_LOG2 = $clog2(WHEEL_SIZE);
  localparam bit          WHEEL_POW2 = ((WHEEL_SIZE & (WHEEL_SIZE - 1)) == 0);
  localparam int unsigned CNT_W      = $clog2(WHEEL_SIZE + 1);

  // Read tree: 16 groups of 16 entries covers every byte address
  localparam int unsigned GRP_W     = BYTE_W / 2;
  localparam int unsigned GRP_SIZE  = 1 << GRP_W;
  localparam int unsigned GRP_NUM   = 1 << (BYTE_W - GRP_W);
  localparam int unsigned TREE_SIZE = GRP_SIZE * GRP_NUM;

  localparam logic [DIV_W-1:0] WHEEL_DIV = DIV_W'(WHEEL_SIZE);

  // Turn count by reciprocal: sum / WHEEL_SIZE == (sum * RCP_M) >> RCP_SH for any
  // sum below 2^SUM_W; the multiply is split into two halves of RCP_M
  localparam int unsigned RCP_SH   = SUM_W + WHEEL_LOG2;
  localparam int unsigned RCP_W    = SUM_W + 1;
  localparam int unsigned RCP_HALF = RCP_W / 2;
  localparam int unsigned PROD_W   = SUM_W + RCP_W;
  localparam logic [63:0] RCP_FULL =
      ((64'd1 << RCP_SH) + 64'(WHEEL_SIZE) - 64'd1) / 64'(WHEEL_SIZE);
  localparam logic [RCP_W-1:0]          RCP_M    = RCP_FULL[RCP_W-1:0];
  localparam logic [RCP_HALF-1:0]       RCP_M_LO = RCP_M[RCP_HALF-1:0];
  localparam logic [RCP_W-RCP_HALF-1:0] RCP_M_HI = RCP_M[RCP_W-1:RCP_HALF];

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [GRP_NUM-1:0][GRP_SIZE-1:0][BYTE_W-1:0] tree_vec_t;
  typedef logic [TREE_SIZE-1:0][BYTE_W-1:0] wrap_tbl_t;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INIT     = 3'd0,
    REQ_PULL     = 3'd1,
    REQ_FINISH   = 3'd2,
    REQ_TICK     = 3'd3,
    REQ_SCRAMBLE = 3'd4
  } req_type_e;

  // Commands broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INIT,
    CELL_PULL,
    CELL_INV_CLR,
    CELL_INV_HIT,
    CELL_INV_COPY
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    byte_t    idx;   // pull index, or value looked up during inversion
    byte_t    val;   // value fed to the last cell, or position during inversion
  } cell_cmd_t;

  // Byte address folded onto the wheel, built at elaboration
  function automatic wrap_tbl_t build_wrap_tbl();
    wrap_tbl_t tbl;
    for (int i = 0; i < TREE_SIZE; i++) begin
      tbl[i] = BYTE_W'(i % WHEEL_SIZE);
    end
    return tbl;
  endfunction

  localparam wrap_tbl_t WRAP_TBL = build_wrap_tbl();

  // Clamp a turn count to the output field
  function automatic logic [TURNS_W-1:0] sat_turns(input logic [SUM_W-1:0] q);
    logic [SUM_W-1:0] lim;
    lim = {{(SUM_W - TURNS_W){1'b0}}, {TURNS_W{1'b1}}};
    if (q > lim) begin
      return '1;
    end
    return q[TURNS_W-1:0];
  endfunction

endpackage

// File: design/rwp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response items.
// Depends on rwp_pkg for field widths.
interface rwp_req_if;
  import rwp_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [BYTE_W-1:0]   byte_operand;
  logic [TICK_W-1:0]   tick_count;

  modport source (output valid, req_type, byte_operand, tick_count, input ready);
  modport sink   (input valid, req_type, byte_operand, tick_count, output ready);
endinterface

interface rwp_rsp_if;
  import rwp_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   data_out;
  logic [TURNS_W-1:0]  turns;

  modport source (output valid, data_out, turns, input ready);
  modport sink   (input valid, data_out, turns, output ready);
endinterface

// File: design/rwp_cell.sv
`timescale 1ns / 1ps
// One wheel position: holds a permutation entry and an inversion scratch entry.
// Depends on rwp_pkg; instantiated as a chain by the top level.
module rwp_cell (
  input  logic                 clk_i,
  input  rwp_pkg::byte_t       cell_idx_i,
  input  rwp_pkg::byte_t       up_val_i,
  input  rwp_pkg::cell_cmd_t   cmd_i,
  output rwp_pkg::byte_t       val_o
);
  import rwp_pkg::*;

  byte_t val_q, val_d;
  byte_t inv_q, inv_d;

  // Per-cell update; pull takes the upper neighbor from the pull index upward
  always_comb begin
    val_d = val_q;
    inv_d = inv_q;
    case (cmd_i.op)
      CELL_HOLD: begin
      end
      CELL_INIT: begin
        val_d = cell_idx_i;
      end
      CELL_PULL: begin
        if (cell_idx_i >= cmd_i.idx) begin
          val_d = up_val_i;
        end
      end
      CELL_INV_CLR: begin
        inv_d = '0;
      end
      CELL_INV_HIT: begin
        if (cell_idx_i == cmd_i.idx) begin
          inv_d = cmd_i.val;
        end
      end
      CELL_INV_COPY: begin
        val_d = inv_q;
      end
      default: begin
      end
    endcase
  end

  // Payload only, no reset: contents are undefined until an init
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    inv_q <= inv_d;
  end

  assign val_o = val_q;

endmodule

// File: design/rwp_read_tree.sv
`timescale 1ns / 1ps
// Two-stage registered read selector over the cell chain outputs.
// Depends on rwp_pkg; the pick within each group and the pick of the group are each registered.
module rwp_read_tree (
  input  logic                 clk_i,
  input  rwp_pkg::byte_t       rd_addr_i,
  input  rwp_pkg::tree_vec_t   entries_i,
  output rwp_pkg::byte_t       rd_data_o
);
  import rwp_pkg::*;

  byte_t            grp_q [GRP_NUM];
  logic [GRP_W-1:0] hi_q;
  byte_t            data_q;
  logic [GRP_W-1:0] lo_sel;

  assign lo_sel = rd_addr_i[GRP_W-1:0];

  // Stage 1 picks within each group, stage 2 picks the group
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < GRP_NUM; g++) begin
      grp_q[g] <= entries_i[g][lo_sel];
    end
    hi_q   <= rd_addr_i[BYTE_W-1:GRP_W];
    data_q <= grp_q[hi_q];
  end

  assign rd_data_o = data_q;

endmodule

// File: design/rotor_wheel_permutation.sv
`timescale 1ns / 1ps
// Top level of the rotor wheel: request decode, offset, turn counter and cell chain.
// Depends on rwp_pkg, rwp_if, rwp_cell and rwp_read_tree.
//
//   Channel  Dir  Handshake     Payload
//   req_i    in   valid/ready   req_type, byte_operand, tick_count
//   rsp_o    out  valid/ready   data_out, turns
//   cfg      in   cfg_we_i      cfg_wdata_i (flipped mode)
//
// Init, finish without inversion, tick and unknown requests complete when accepted.
// Pull and scramble read the entry through the two-stage read tree in S_READ_A,
// S_READ_B and S_READ_USE. Finish in flipped mode sweeps the wheel, one read per cycle.
// With a wheel size that is not a power of two, tick runs S_MUL_LO then S_MUL_HI: the
// turn count comes from a reciprocal multiply split over two steps.
// Reset clears control state and the offset only; the wheel is undefined until an init.
// A waiting response item does not block a new request; a finished item parks until
// the output register frees.
module rotor_wheel_permutation (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwp_req_if.sink    req_i,
  rwp_rsp_if.source  rsp_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);
  import rwp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_A,
    S_READ_B,
    S_READ_USE,
    S_INV,
    S_MUL_LO,
    S_MUL_HI,
    S_EMIT
  } state_e;

  state_e               state_q;
  logic                 flipped_q;
  byte_t                offset_q;
  req_type_e            op_q;
  byte_t                pull_idx_q;
  byte_t                rd_addr_q;
  logic [CNT_W-1:0]     inv_cnt_q;
  logic                 tag1_vld_q, tag2_vld_q;
  byte_t                tag1_k_q, tag2_k_q;
  logic [SUM_W-1:0]     tick_sum_q;
  logic [PROD_W-1:0]    prod_q;
  logic                 out_valid_q;
  byte_t                out_data_q;
  logic [TURNS_W-1:0]   out_turns_q;
  byte_t                pend_data_q;
  logic [TURNS_W-1:0]   pend_turns_q;

  req_type_e                       req_code;
  logic                            accept;
  logic                            out_free;
  logic                            out_load;
  logic [SUM_W-1:0]                sum;
  logic                            pull_ok;
  byte_t                           scr_addr;
  byte_t                           rd_data;
  byte_t                           scr_data;
  logic                            inv_issue;
  logic                            inv_done;
  logic [SUM_W+RCP_HALF-1:0]       mul_lo;
  logic [SUM_W+RCP_W-RCP_HALF-1:0] mul_hi;
  logic [PROD_W-1:0]               prod_all;
  logic [SUM_W-1:0]                tick_turns;
  logic                            fin_now;
  byte_t                           fin_data;
  logic [TURNS_W-1:0]              fin_turns;
  cell_cmd_t                       cell_cmd;
  byte_t                           cell_val [WHEEL_SIZE];
  wire tree_vec_t                  tree_vec;

  // Handshake
  assign req_code     = req_type_e'(req_i.req_type);
  assign req_i.ready  = (state_q == S_IDLE);
  assign accept       = req_i.valid && req_i.ready;
  assign out_free     = !out_valid_q || rsp_o.ready;
  assign out_load     = out_free && (fin_now || (state_q == S_EMIT));
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.data_out = out_data_q;
  assign rsp_o.turns    = out_turns_q;

  // Datapath helpers
  assign sum      = SUM_W'(offset_q) + SUM_W'(req_i.tick_count);
  assign pull_ok  = ({1'b0, req_i.byte_operand} < WHEEL_DIV);
  assign scr_addr = flipped_q ? WRAP_TBL[req_i.byte_operand]
                              : WRAP_TBL[byte_t'(req_i.byte_operand + offset_q)];
  assign scr_data = flipped_q ? byte_t'(rd_data - offset_q) : rd_data;

  // Inversion sweep bookkeeping
  assign inv_issue = (state_q == S_INV) && (inv_cnt_q != CNT_W'(WHEEL_SIZE));
  assign inv_done  = (state_q == S_INV) && !inv_issue && !tag1_vld_q && !tag2_vld_q;

  // Reciprocal multiply: low half first, high half and sum in the second step
  assign mul_lo     = tick_sum_q * RCP_M_LO;
  assign mul_hi     = tick_sum_q * RCP_M_HI;
  assign prod_all   = prod_q + {mul_hi, {RCP_HALF{1'b0}}};
  assign tick_turns = SUM_W'(prod_all[PROD_W-1:RCP_SH]);

  // Completion of the current item and its result
  always_comb begin
    fin_now   = 1'b0;
    fin_data  = '0;
    fin_turns = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_code)
            REQ_PULL:     fin_now = !pull_ok;
            REQ_FINISH:   fin_now = !flipped_q;
            REQ_TICK: begin
              fin_now   = WHEEL_POW2;
              fin_turns = sat_turns(sum >> WHEEL_LOG2);
            end
            REQ_SCRAMBLE: fin_now = 1'b0;
            default:      fin_now = 1'b1;
          endcase
        end
      end
      S_READ_USE: begin
        fin_now = 1'b1;
        if (op_q == REQ_SCRAMBLE) begin
          fin_data = scr_data;
        end
      end
      S_INV: begin
        fin_now = inv_done;
      end
      S_MUL_HI: begin
        fin_now   = 1'b1;
        fin_turns = sat_turns(tick_turns);
      end
      default: begin
      end
    endcase
  end

  // Command broadcast to the cell chain
  always_comb begin
    cell_cmd.op  = CELL_HOLD;
    cell_cmd.idx = pull_idx_q;
    cell_cmd.val = rd_data;
    case (state_q)
      S_IDLE: begin
        if (accept && req_code == REQ_INIT) begin
          cell_cmd.op = CELL_INIT;
        end else if (accept && req_code == REQ_FINISH && flipped_q) begin
          cell_cmd.op = CELL_INV_CLR;
        end
      end
      S_READ_USE: begin
        if (op_q == REQ_PULL) begin
          cell_cmd.op = CELL_PULL;
        end
      end
      S_INV: begin
        if (tag2_vld_q) begin
          cell_cmd.op  = CELL_INV_HIT;
          cell_cmd.idx = rd_data;
          cell_cmd.val = tag2_k_q;
        end else if (inv_done) begin
          cell_cmd.op = CELL_INV_COPY;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state machine, offset, turn multiply and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      flipped_q    <= 1'b0;
      offset_q     <= '0;
      op_q         <= REQ_INIT;
      pull_idx_q   <= '0;
      rd_addr_q    <= '0;
      inv_cnt_q    <= '0;
      tag1_vld_q   <= 1'b0;
      tag2_vld_q   <= 1'b0;
      tag1_k_q     <= '0;
      tag2_k_q     <= '0;
      tick_sum_q   <= '0;
      prod_q       <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_turns_q  <= '0;
      pend_data_q  <= '0;
      pend_turns_q <= '0;
    end else begin
      if (cfg_we_i) begin
        flipped_q <= cfg_wdata_i;
      end

      // Tags follow the read tree latency during inversion
      tag1_vld_q <= inv_issue;
      tag1_k_q   <= rd_addr_q;
      tag2_vld_q <= tag1_vld_q;
      tag2_k_q   <= tag1_k_q;

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q <= req_code;
            case (req_code)
              REQ_PULL: begin
                if (pull_ok) begin
                  pull_idx_q <= req_i.byte_operand;
                  rd_addr_q  <= req_i.byte_operand;
                  state_q    <= S_READ_A;
                end
              end
              REQ_FINISH: begin
                offset_q <= req_i.byte_operand;
                if (flipped_q) begin
                  rd_addr_q <= '0;
                  inv_cnt_q <= '0;
                  state_q   <= S_INV;
                end
              end
              REQ_TICK: begin
                offset_q <= sum[BYTE_W-1:0];
                if (!WHEEL_POW2) begin
                  tick_sum_q <= sum;
                  state_q    <= S_MUL_LO;
                end
              end
              REQ_SCRAMBLE: begin
                rd_addr_q <= scr_addr;
                state_q   <= S_READ_A;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ_A: state_q <= S_READ_B;
        S_READ_B: state_q <= S_READ_USE;
        S_READ_USE: begin
        end
        S_INV: begin
          if (inv_issue) begin
            rd_addr_q <= rd_addr_q + 1'b1;
            inv_cnt_q <= inv_cnt_q + 1'b1;
          end
        end
        S_MUL_LO: begin
          prod_q  <= PROD_W'(mul_lo);
          state_q <= S_MUL_HI;
        end
        S_MUL_HI: begin
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= pend_data_q;
            out_turns_q <= pend_turns_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Finished item goes to the output register, or parks until it frees
      if (fin_now) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
          out_data_q  <= fin_data;
          out_turns_q <= fin_turns;
          state_q     <= S_IDLE;
        end else begin
          pend_data_q  <= fin_data;
          pend_turns_q <= fin_turns;
          state_q      <= S_EMIT;
        end
      end

      // Output item taken and nothing new loaded
      if (rsp_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Cell chain: each cell hands its entry down on a pull, the last one takes the picked entry
  for (genvar c = 0; c < WHEEL_SIZE; c++) begin : g_cell
    byte_t up_val;
    if (c == WHEEL_SIZE - 1) begin : g_last
      assign up_val = cell_cmd.val;
    end else begin : g_mid
      assign up_val = cell_val[c + 1];
    end
    rwp_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (BYTE_W'(c)),
      .up_val_i   (up_val),
      .cmd_i      (cell_cmd),
      .val_o      (cell_val[c])
    );
  end

  // Read tree input, padded with zeros past the wheel
  for (genvar t = 0; t < TREE_SIZE; t++) begin : g_pad
    if (t < WHEEL_SIZE) begin : g_used
      assign tree_vec[t / GRP_SIZE][t % GRP_SIZE] = cell_val[t];
    end else begin : g_zero
      assign tree_vec[t / GRP_SIZE][t % GRP_SIZE] = '0;
    end
  end

  rwp_read_tree u_read_tree (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr_q),
    .entries_i (tree_vec),
    .rd_data_o (rd_data)
  );

endmodule

// File: dv/rwp_wheel_checker.sv
`timescale 1ns / 1ps
// Watches the request, response and config ports of the rotor wheel, predicts each
// response item and compares it field by field. Depends on rwp_pkg and rwp_if.
module rwp_wheel_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rwp_req_if   req_i,
  rwp_rsp_if   rsp_i,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  output int   mismatch_count_o,
  output int   pending_count_o
);
  import rwp_pkg::*;

  typedef struct packed {
    byte_t              data_out;
    logic [TURNS_W-1:0] turns;
  } wheel_rsp_t;

  // Predicted wheel state
  byte_t      wheel_q [WHEEL_SIZE];
  byte_t      offset_q;
  logic       flipped_q;
  wheel_rsp_t due_rsp_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    // keep the log short if things go badly wrong
    if (mismatch_count_o < 30) begin
      $display("[%0t] wheel check: %s: got 0x%0h, want 0x%0h", $time, what, got_v, want_v);
    end
    mismatch_count_o++;
  endtask

  // Advance the predicted wheel by one request and return its response item
  function automatic wheel_rsp_t apply_request(input logic [REQ_W-1:0] kind,
                                               input byte_t operand,
                                               input logic [TICK_W-1:0] steps);
    wheel_rsp_t       rsp;
    byte_t            picked;
    byte_t            idx;
    byte_t            inv [WHEEL_SIZE];
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] whole;
    rsp = '0;
    case (kind)
      REQ_INIT: begin
        for (int i = 0; i < WHEEL_SIZE; i++) wheel_q[i] = byte_t'(i);
      end
      REQ_PULL: begin
        // out-of-range index leaves the wheel alone
        if (operand < WHEEL_SIZE) begin
          picked = wheel_q[operand];
          for (int i = operand; i < WHEEL_SIZE - 1; i++) wheel_q[i] = wheel_q[i + 1];
          wheel_q[WHEEL_SIZE - 1] = picked;
        end
      end
      REQ_FINISH: begin
        offset_q = operand;
        if (flipped_q) begin
          // positions never hit stay zero; a later position wins
          for (int i = 0; i < WHEEL_SIZE; i++) inv[i] = '0;
          for (int i = 0; i < WHEEL_SIZE; i++) begin
            if (wheel_q[i] < WHEEL_SIZE) inv[wheel_q[i]] = byte_t'(i);
          end
          wheel_q = inv;
        end
      end
      REQ_TICK: begin
        sum   = SUM_W'(offset_q) + SUM_W'(steps);
        whole = sum / WHEEL_SIZE;
        rsp.turns = (whole > SUM_W'({TURNS_W{1'b1}})) ? '1 : whole[TURNS_W-1:0];
        offset_q  = sum[BYTE_W-1:0];
      end
      REQ_SCRAMBLE: begin
        if (flipped_q) begin
          rsp.data_out = wheel_q[operand % WHEEL_SIZE] - offset_q;
        end else begin
          idx = operand + offset_q;
          rsp.data_out = wheel_q[idx % WHEEL_SIZE];
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Track config, retire response items, then queue predictions for new requests
  always @(posedge clk_i or negedge rst_ni) begin
    wheel_rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < WHEEL_SIZE; i++) wheel_q[i] = '0;
      offset_q  = '0;
      flipped_q = 1'b0;
      due_rsp_q.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (cfg_we_i) flipped_q = cfg_wdata_i;
      // a response can only belong to a request from an earlier edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (due_rsp_q.size() == 0) begin
          report_mismatch("response item with no request waiting", rsp_i.data_out, 0);
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp_i.data_out !== want.data_out) begin
            report_mismatch("data_out", rsp_i.data_out, want.data_out);
          end
          if (rsp_i.turns !== want.turns) begin
            report_mismatch("turns", rsp_i.turns, want.turns);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        due_rsp_q.push_back(apply_request(req_i.req_type, req_i.byte_operand,
                                          req_i.tick_count));
      end
      pending_count_o = due_rsp_q.size();
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the rotor wheel testbench: clock, reset, request stimulus, response drain
// and verdict. Depends on rwp_pkg, rwp_if, rwp_wheel_checker and the block itself.
module testbench;
  import rwp_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 650;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   mismatch_count;
  int   pending_count;
  int   req_idle_pct;
  int   rsp_idle_pct;
  bit   hold_request;
  int   cycle_count;
  int   sent_total;
  int   sent_by_kind [8];

  rwp_req_if req_ch ();
  rwp_rsp_if rsp_ch ();

  rotor_wheel_permutation dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  rwp_wheel_checker wheel_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_i           (req_ch),
    .rsp_i           (rsp_ch),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  // Clock
  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d response items outstanding",
               cycle_count, pending_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Response drain: random back-pressure, plus one long hold-off on request
  initial begin : rsp_drain
    bit held;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_ch.ready <= ($urandom_range(99, 0) >= rsp_idle_pct);
    end
  end

  // Offer one request item and wait until it is taken; called and returns at negedge
  task automatic send_request(input logic [REQ_W-1:0] kind, input byte_t operand,
                              input logic [TICK_W-1:0] steps);
    while ($urandom_range(99, 0) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.byte_operand <= operand;
    req_ch.tick_count   <= steps;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_by_kind[kind]++;
    sent_total++;
  endtask

  // Drain everything, then write the mode bit
  task automatic set_flipped_mode(input logic mode);
    req_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Tick counts: small, full range, near the top, and scaled down
  function automatic logic [TICK_W-1:0] pick_tick_steps();
    case ($urandom_range(3, 0))
      0:       return TICK_W'($urandom_range(600, 0));
      1:       return $urandom();
      2:       return '1 - TICK_W'($urandom_range(300, 0));
      default: return $urandom() >> $urandom_range(31, 0);
    endcase
  endfunction

  // Mostly well-formed setups (pulls, finish) followed by use, some raw noise
  task automatic run_wheel_traffic(input int n_items);
    int goal;
    int n_pulls;
    int n_uses;
    goal = sent_total + n_items;
    while (sent_total < goal) begin
      if ($urandom_range(99, 0) < 15) begin
        repeat ($urandom_range(4, 1)) begin
          send_request(REQ_W'($urandom_range(7, 0)), byte_t'($urandom_range(255, 0)),
                       $urandom());
        end
      end else begin
        if ($urandom_range(1, 0) == 1) begin
          send_request(REQ_INIT, byte_t'($urandom_range(255, 0)), $urandom());
        end
        n_pulls = $urandom_range(40, 4);
        repeat (n_pulls) begin
          send_request(REQ_PULL, byte_t'($urandom_range(255, 0)), $urandom());
        end
        send_request(REQ_FINISH, byte_t'($urandom_range(255, 0)), $urandom());
        n_uses = $urandom_range(30, 5);
        repeat (n_uses) begin
          if ($urandom_range(99, 0) < 70) begin
            send_request(REQ_SCRAMBLE, byte_t'($urandom_range(255, 0)), $urandom());
          end else begin
            send_request(REQ_TICK, byte_t'($urandom_range(255, 0)), pick_tick_steps());
          end
        end
      end
    end
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = '0;
    req_ch.byte_operand = '0;
    req_ch.tick_count   = '0;
    hold_request        = 1'b0;
    req_idle_pct        = 15;
    rsp_idle_pct        = 61;
    sent_total          = 0;
    foreach (sent_by_kind[k]) sent_by_kind[k] = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: forward mode, field extremes and every request code
    set_flipped_mode(1'b0);
    send_request(REQ_INIT, 8'h00, '0);
    send_request(REQ_SCRAMBLE, 8'h00, '0);
    send_request(REQ_SCRAMBLE, 8'hff, '1);
    send_request(REQ_TICK, 8'h00, '0);
    send_request(REQ_TICK, 8'hff, '1);
    send_request(REQ_TICK, 8'h00, '1);           // largest turn count
    send_request(REQ_TICK, 8'h00, 32'd1);
    send_request(REQ_SCRAMBLE, 8'h01, '0);       // index wraps past the top
    send_request(REQ_PULL, 8'h00, '0);
    send_request(REQ_PULL, 8'hff, '1);
    send_request(REQ_PULL, 8'h80, '0);
    send_request(REQ_FINISH, 8'hff, '0);
    send_request(REQ_SCRAMBLE, 8'h00, '0);
    send_request(REQ_SCRAMBLE, 8'hc8, '0);
    send_request(3'd5, 8'hff, '1);               // unused codes do nothing
    send_request(3'd6, 8'h00, '0);
    send_request(3'd7, 8'hff, '1);
    send_request(REQ_FINISH, 8'h00, '1);

    // Directed: flipped mode, inversion and subtract path
    set_flipped_mode(1'b1);
    send_request(REQ_FINISH, 8'h80, '0);
    send_request(REQ_SCRAMBLE, 8'h00, '0);
    send_request(REQ_SCRAMBLE, 8'hff, '0);
    send_request(REQ_TICK, 8'h00, 32'h100);
    send_request(REQ_PULL, 8'hff, '0);
    send_request(REQ_FINISH, 8'h00, '0);
    send_request(REQ_SCRAMBLE, 8'h11, '0);

    // Random, flipped mode; the drain holds off early on to fill the block
    hold_request = 1'b1;
    run_wheel_traffic(RANDOM_ITEMS / 3);

    // Random, forward mode, roles of the two idle rates swapped
    set_flipped_mode(1'b0);
    req_idle_pct = 61;
    rsp_idle_pct = 15;
    run_wheel_traffic(RANDOM_ITEMS / 3);

    // Random, flipped mode, no idling
    set_flipped_mode(1'b1);
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    run_wheel_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    req_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (WHEEL_SIZE + 40) @(negedge clk);

    $display("Run covered %0d request items: %0d init, %0d pull, %0d finish, %0d tick,",
             sent_total, sent_by_kind[REQ_INIT], sent_by_kind[REQ_PULL],
             sent_by_kind[REQ_FINISH], sent_by_kind[REQ_TICK]);
    $display("%0d scramble, %0d unused codes, both mapping modes; %0d mismatches",
             sent_by_kind[REQ_SCRAMBLE], sent_by_kind[5] + sent_by_kind[6] + sent_by_kind[7],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
